[design/ccpr_pkg.sv]
// shared types, constants and crc helper for the checked packet ring
// no dependencies
`timescale 1ns / 1ps

package ccpr_pkg;

   localparam int MaxSlotsDefault     = 16;
   localparam int MaxSlotBytesDefault = 256;
   localparam int HdrBytes            = 24;
   localparam logic [31:0] CrcPoly    = 32'hEDB8_8320;
   localparam logic [31:0] CrcInit    = 32'hFFFF_FFFF;

   localparam logic [2:0] StOk       = 3'd0;
   localparam logic [2:0] StTooLarge = 3'd1;
   localparam logic [2:0] StFull     = 3'd2;
   localparam logic [2:0] StEmpty    = 3'd3;
   localparam logic [2:0] StCrcSkip  = 3'd4;

   localparam logic [0:0] OpPush = 1'b0;
   localparam logic [0:0] OpPop  = 1'b1;

   localparam logic [0:0] RegSlotCount = 1'b0;
   localparam logic [0:0] RegSlotBytes = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUSH,
      ST_WALK,
      ST_READ,
      ST_FETCH,
      ST_RESP
   } ctrl_state_type;

   // one crc unit step: byte in, eight shift/xor steps
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
      end
      return c;
   endfunction

endpackage

[design/ccpr_store.sv]
// payload memory: one write port, one registered read port
// no dependencies
`timescale 1ns / 1ps

module ccpr_store #(
   parameter int AddrWidth = 12
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrWidth-1:0] wr_addr,
   input  logic [7:0]           wr_data,
   input  logic [AddrWidth-1:0] rd_addr,
   output logic [7:0]           rd_data
);

   logic [7:0] mem [0:(1<<AddrWidth)-1];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/ccpr_crc_unit.sv]
// crc-32 accumulator for the walk, one byte per cycle while step is high
// depends on ccpr_pkg
`timescale 1ns / 1ps

module ccpr_crc_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        clear,
   input  logic        step,
   input  logic [7:0]  data,
   output logic [31:0] crc
);

   logic [31:0] crc_ff, crc_in;

   always_comb begin
      crc_in = crc_ff;
      if (clear) begin
         crc_in = ccpr_pkg::CrcInit;
      end else if (step) begin
         crc_in = ccpr_pkg::crc_byte(crc_ff, data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= ccpr_pkg::CrcInit;
      end else begin
         crc_ff <= crc_in;
      end
   end

   assign crc = crc_ff;

endmodule

[design/crc_checked_packet_ring_core.sv]
// top level of the crc checked packet ring: sequencer, slot tables, counters
// depends on ccpr_pkg, ccpr_store, ccpr_crc_unit
`timescale 1ns / 1ps

// a push passes the push state, then the response state (or ready for a non-last push);
// a pop passes read, fetch and response (read, response on an empty ring), with the walk
// state on the first pop of a nonzero-size packet; a stalled response holds in its state
// throughput: one transaction at a time, the next accept comes the cycle after the response
// is taken; the single memory read port and crc unit set the rate
// reset: synchronous active high; clears indexes, counters and sequencer, no memory clearing

module crc_checked_packet_ring_core #(
   parameter int MAX_SLOTS      = ccpr_pkg::MaxSlotsDefault,
   parameter int MAX_SLOT_BYTES = ccpr_pkg::MaxSlotBytesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_last_byte,
   input  logic [7:0]  req_message_type,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_byte_valid,
   output logic        rsp_out_last,
   output logic [7:0]  rsp_out_type,
   output logic [7:0]  rsp_out_size,
   output logic [3:0]  rsp_pending_count,
   output logic [31:0] rsp_overflow_count,
   output logic [31:0] rsp_crc_error_count,
   output logic [31:0] rsp_written_count,
   output logic [31:0] rsp_read_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [8:0]  csr_data
);

   localparam int SlotW = $clog2(MAX_SLOTS);
   localparam int OffW  = $clog2(MAX_SLOT_BYTES);
   localparam int AddrW = SlotW + OffW;

   // configuration
   logic [4:0] slot_count_ff;
   logic [8:0] slot_bytes_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= 5'd16;
         slot_bytes_ff <= 9'd256;
      end else if (csr_valid) begin
         unique case (csr_index)
            ccpr_pkg::RegSlotCount: slot_count_ff <= csr_data[4:0];
            ccpr_pkg::RegSlotBytes: slot_bytes_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // clamped effective count and payload limit
   logic [8:0] eff_count;
   logic [12:0] eff_bytes;
   logic [12:0] limit;

   always_comb begin
      eff_count = {4'd0, slot_count_ff};
      if (eff_count < 9'd2) eff_count = 9'd2;
      if (32'(eff_count) > MAX_SLOTS) eff_count = 9'(MAX_SLOTS);
      eff_bytes = {4'd0, slot_bytes_ff};
      if (eff_bytes < 13'(ccpr_pkg::HdrBytes + 1)) eff_bytes = 13'(ccpr_pkg::HdrBytes + 1);
      if (32'(eff_bytes) > MAX_SLOT_BYTES) eff_bytes = 13'(MAX_SLOT_BYTES);
      limit = eff_bytes - 13'(ccpr_pkg::HdrBytes);
   end

   function automatic logic [SlotW-1:0] next_idx(input logic [SlotW-1:0] i,
                                                  input logic [8:0] c);
      logic [8:0] n;
      n = 9'(i) + 9'd1;
      return (n >= c) ? '0 : n[SlotW-1:0];
   endfunction

   // ring state
   logic [SlotW-1:0] wr_idx_ff, rd_idx_ff;
   logic [12:0]      push_len_ff;
   logic [7:0]       pop_off_ff;
   logic             pop_checked_ff;
   logic [31:0]      overflows_ff, crc_errors_ff, written_ff, read_ff;

   // slot tables (small, flop arrays)
   logic [7:0]  size_tab [0:MAX_SLOTS-1];
   logic [7:0]  type_tab [0:MAX_SLOTS-1];
   logic [31:0] crc_tab  [0:MAX_SLOTS-1];

   // captured request
   logic       present_ff, last_ff;
   logic [7:0] data_ff, mtype_ff;

   // walk counter
   logic [8:0] walk_cnt_ff;

   // response register
   logic [2:0] r_status_ff;
   logic [7:0] r_byte_ff, r_type_ff, r_size_ff;
   logic       r_bv_ff, r_last_ff;

   ccpr_pkg::ctrl_state_type state_ff, state_in;

   // shared units
   logic             mem_we;
   logic [AddrW-1:0] mem_waddr, mem_raddr;
   logic [7:0]       mem_rdata;
   logic             crc_clear, crc_step;
   logic [7:0]       crc_data;
   logic [31:0]      crc_val;

   ccpr_store #(.AddrWidth(AddrW)) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (data_ff),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   ccpr_crc_unit u_crc (
      .clock (clock),
      .reset (reset),
      .clear (crc_clear),
      .step  (crc_step),
      .data  (crc_data),
      .crc   (crc_val)
   );

   logic [7:0] cur_size;
   assign cur_size = size_tab[rd_idx_ff];
   logic fire;
   assign fire = req_valid && req_ready;
   logic is_empty;
   assign is_empty = (rd_idx_ff == wr_idx_ff);
   logic need_walk;
   assign need_walk = !pop_checked_ff;
   // the last stored byte has been folded into the crc in the cycle after its step
   logic walk_done;
   assign walk_done = (walk_cnt_ff == {1'b0, cur_size} + 9'd1);

   // push context crc is kept here; the crc unit does the walk
   logic [31:0] push_crc_ff;
   logic        store_ok;
   assign store_ok = present_ff && (push_len_ff < limit);

   // crc unit feed: the memory read data drives the step, and only the walk steps the unit
   assign crc_data = mem_rdata;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ccpr_pkg::ST_IDLE: if (fire) begin
            state_in = (req_opcode == ccpr_pkg::OpPop) ? ccpr_pkg::ST_READ : ccpr_pkg::ST_PUSH;
         end
         ccpr_pkg::ST_PUSH: state_in = last_ff ? ccpr_pkg::ST_RESP : ccpr_pkg::ST_IDLE;
         ccpr_pkg::ST_READ: begin
            if (is_empty) state_in = ccpr_pkg::ST_RESP;
            else if (need_walk && cur_size != 8'd0) state_in = ccpr_pkg::ST_WALK;
            else state_in = ccpr_pkg::ST_FETCH;
         end
         ccpr_pkg::ST_WALK: if (walk_done) state_in = ccpr_pkg::ST_FETCH;
         ccpr_pkg::ST_FETCH: state_in = ccpr_pkg::ST_RESP;
         ccpr_pkg::ST_RESP: if (rsp_ready) state_in = ccpr_pkg::ST_IDLE;
         default: state_in = ccpr_pkg::ST_IDLE;
      endcase
   end

   // outputs / unit controls
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = {wr_idx_ff, push_len_ff[OffW-1:0]};
      mem_raddr = {rd_idx_ff, pop_off_ff[OffW-1:0]};
      crc_clear = 1'b0;
      crc_step  = 1'b0;
      unique case (state_ff)
         ccpr_pkg::ST_PUSH: mem_we = store_ok;
         ccpr_pkg::ST_READ: crc_clear = 1'b1;
         ccpr_pkg::ST_WALK: begin
            // data for walk_cnt_ff-1 is on the read port; prefetch the next one
            crc_step = (walk_cnt_ff != 9'd0);
            // at the end, point the read port at the byte the pop will return
            if (!walk_done) mem_raddr = {rd_idx_ff, walk_cnt_ff[OffW-1:0]};
         end
         default: ;
      endcase
   end

   assign req_ready = (state_ff == ccpr_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == ccpr_pkg::ST_RESP);

   // pop decision at the end of the check
   logic [31:0] walk_crc_final;
   assign walk_crc_final = ((cur_size == 8'd0) ? ccpr_pkg::CrcInit : crc_val) ^ ccpr_pkg::CrcInit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ccpr_pkg::ST_IDLE;
         wr_idx_ff      <= '0;
         rd_idx_ff      <= '0;
         push_len_ff    <= '0;
         push_crc_ff    <= ccpr_pkg::CrcInit;
         pop_off_ff     <= '0;
         pop_checked_ff <= 1'b0;
         overflows_ff   <= '0;
         crc_errors_ff  <= '0;
         written_ff     <= '0;
         read_ff        <= '0;
         walk_cnt_ff    <= '0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            ccpr_pkg::ST_IDLE: ;
            ccpr_pkg::ST_PUSH: begin
               logic [12:0] len;
               len = push_len_ff;
               if (last_ff) push_crc_ff <= ccpr_pkg::CrcInit;
               else if (store_ok) push_crc_ff <= ccpr_pkg::crc_byte(push_crc_ff, data_ff);
               if (present_ff && push_len_ff <= limit) len = push_len_ff + 13'd1;
               push_len_ff <= last_ff ? 13'd0 : len;
               if (last_ff) begin
                  if (len > limit) begin
                     r_status_ff <= ccpr_pkg::StTooLarge;
                  end else if (next_idx(wr_idx_ff, eff_count) == rd_idx_ff) begin
                     overflows_ff <= overflows_ff + 32'd1;
                     r_status_ff  <= ccpr_pkg::StFull;
                  end else begin
                     size_tab[wr_idx_ff] <= len[7:0];
                     type_tab[wr_idx_ff] <= mtype_ff;
                     crc_tab[wr_idx_ff]  <= (store_ok ? ccpr_pkg::crc_byte(push_crc_ff, data_ff)
                                                      : push_crc_ff) ^ ccpr_pkg::CrcInit;
                     wr_idx_ff  <= next_idx(wr_idx_ff, eff_count);
                     written_ff <= written_ff + 32'd1;
                     r_status_ff <= ccpr_pkg::StOk;
                  end
                  r_byte_ff <= '0;
                  r_bv_ff   <= 1'b0;
                  r_last_ff <= 1'b0;
                  r_type_ff <= '0;
                  r_size_ff <= '0;
               end
            end
            ccpr_pkg::ST_READ: begin
               if (is_empty) begin
                  walk_cnt_ff <= '0;
                  r_status_ff <= ccpr_pkg::StEmpty;
                  r_byte_ff <= '0;
                  r_bv_ff   <= 1'b0;
                  r_last_ff <= 1'b0;
                  r_type_ff <= '0;
                  r_size_ff <= '0;
               end else if (!need_walk || cur_size == 8'd0) begin
                  // zero-size check compares init crc against the table
                  if (need_walk && (32'd0 != crc_tab[rd_idx_ff])) begin
                     walk_cnt_ff   <= '0;
                     crc_errors_ff <= crc_errors_ff + 32'd1;
                     rd_idx_ff     <= next_idx(rd_idx_ff, eff_count);
                     pop_off_ff    <= '0;
                     r_status_ff   <= ccpr_pkg::StCrcSkip;
                     r_byte_ff <= '0;
                     r_bv_ff   <= 1'b0;
                     r_last_ff <= 1'b0;
                     r_type_ff <= type_tab[rd_idx_ff];
                     r_size_ff <= cur_size;
                  end else begin
                     // checked packet: the byte at the pop offset is read this cycle
                     // and picked up in the fetch cycle
                     pop_checked_ff <= 1'b1;
                     walk_cnt_ff    <= 9'h1FF;
                  end
               end else begin
                  walk_cnt_ff <= 9'd0;
               end
            end
            ccpr_pkg::ST_WALK: begin
               if (walk_done) begin
                  if (walk_crc_final != crc_tab[rd_idx_ff]) begin
                     crc_errors_ff <= crc_errors_ff + 32'd1;
                     rd_idx_ff     <= next_idx(rd_idx_ff, eff_count);
                     pop_off_ff    <= '0;
                     r_status_ff   <= ccpr_pkg::StCrcSkip;
                     r_byte_ff <= '0;
                     r_bv_ff   <= 1'b0;
                     r_last_ff <= 1'b0;
                     r_type_ff <= type_tab[rd_idx_ff];
                     r_size_ff <= cur_size;
                     walk_cnt_ff <= '0;
                  end else begin
                     pop_checked_ff <= 1'b1;
                     walk_cnt_ff    <= 9'h1FF;
                  end
               end else begin
                  walk_cnt_ff <= walk_cnt_ff + 9'd1;
               end
            end
            ccpr_pkg::ST_RESP: ;
            default: ;
         endcase

         // deliver a pop (a byte, or none for a zero-size packet): marker 1FF set when checked pop proceeds
         if (walk_cnt_ff == 9'h1FF && state_ff == ccpr_pkg::ST_FETCH) begin
            logic [7:0] noff;
            walk_cnt_ff <= '0;
            noff = pop_off_ff + 8'd1;
            r_status_ff <= ccpr_pkg::StOk;
            r_type_ff   <= type_tab[rd_idx_ff];
            r_size_ff   <= cur_size;
            if (cur_size == 8'd0) begin
               r_byte_ff <= '0;
               r_bv_ff   <= 1'b0;
               r_last_ff <= 1'b1;
               rd_idx_ff <= next_idx(rd_idx_ff, eff_count);
               read_ff   <= read_ff + 32'd1;
               pop_checked_ff <= 1'b0;
               pop_off_ff <= '0;
            end else begin
               r_byte_ff <= mem_rdata;
               r_bv_ff   <= 1'b1;
               if (noff >= cur_size) begin
                  r_last_ff <= 1'b1;
                  rd_idx_ff <= next_idx(rd_idx_ff, eff_count);
                  read_ff   <= read_ff + 32'd1;
                  pop_checked_ff <= 1'b0;
                  pop_off_ff <= '0;
               end else begin
                  r_last_ff  <= 1'b0;
                  pop_off_ff <= noff;
               end
            end
         end
      end
   end

   // capture request
   always_ff @(posedge clock) begin
      if (fire) begin
         data_ff    <= req_data_byte;
         present_ff <= req_byte_present;
         last_ff    <= req_last_byte;
         mtype_ff   <= req_message_type;
      end
   end

   logic [3:0] pending;
   always_comb begin
      logic [8:0] p;
      if (wr_idx_ff >= rd_idx_ff) p = 9'(wr_idx_ff) - 9'(rd_idx_ff);
      else p = eff_count - 9'(rd_idx_ff) + 9'(wr_idx_ff);
      pending = p[3:0];
   end

   assign rsp_status          = r_status_ff;
   assign rsp_out_byte        = r_byte_ff;
   assign rsp_out_byte_valid  = r_bv_ff;
   assign rsp_out_last        = r_last_ff;
   assign rsp_out_type        = r_type_ff;
   assign rsp_out_size        = r_size_ff;
   assign rsp_pending_count   = pending;
   assign rsp_overflow_count  = overflows_ff;
   assign rsp_crc_error_count = crc_errors_ff;
   assign rsp_written_count   = written_ff;
   assign rsp_read_count      = read_ff;

endmodule

[design/ccpr_checker.sv]
// port level checks for the packet ring core, bound to the top level
// depends on ccpr_pkg and crc_checked_packet_ring_core
`timescale 1ns / 1ps

module ccpr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_out_byte_valid
);

   // no new transaction while a response waits
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("ready while response pending");

   // a byte is only shown with ok status
   a_byte_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_byte_valid |-> rsp_status == ccpr_pkg::StOk)
      else $error("byte with bad status");

   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_byte_valid |-> rsp_out_byte == 8'd0)
      else $error("stale byte");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response dropped");

endmodule

bind crc_checked_packet_ring_core ccpr_checker u_ccpr_checker (.*);

[tb/sv/crc_checked_packet_ring_core_tb.sv]
// self-checking testbench for the crc checked packet ring core
// depends on ccpr_pkg and crc_checked_packet_ring_core
`timescale 1ns / 1ps

module crc_checked_packet_ring_core_tb;

   localparam int CycleLimit = 2000000;
   localparam int NumSlots   = ccpr_pkg::MaxSlotsDefault;
   localparam int SlotStride = ccpr_pkg::MaxSlotBytesDefault;

   // one result transaction as seen on the rsp_ port
   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic        last;
      logic [7:0]  msg_type;
      logic [7:0]  size;
      logic [3:0]  pending;
      logic [31:0] overflows;
      logic [31:0] crc_errors;
      logic [31:0] written;
      logic [31:0] delivered;
   } ring_rsp_type;

   // directed stimulus row; st_known marks rows whose status is typed in
   typedef struct {
      logic [0:0] op;
      logic [7:0] data;
      logic       present;
      logic       last;
      logic [7:0] mtype;
      bit         st_known;
      logic [2:0] st;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_opcode;
   logic [7:0]  req_data_byte;
   logic        req_byte_present;
   logic        req_last_byte;
   logic [7:0]  req_message_type;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_out_byte;
   logic        rsp_out_byte_valid;
   logic        rsp_out_last;
   logic [7:0]  rsp_out_type;
   logic [7:0]  rsp_out_size;
   logic [3:0]  rsp_pending_count;
   logic [31:0] rsp_overflow_count;
   logic [31:0] rsp_crc_error_count;
   logic [31:0] rsp_written_count;
   logic [31:0] rsp_read_count;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [8:0]  csr_data;

   // typed status travels alongside the request it belongs to
   bit          drv_st_known;
   logic [2:0]  drv_st;

   // mirror of the ring state
   logic [7:0]  mirror_store [NumSlots*SlotStride];
   logic [7:0]  mirror_size [NumSlots];
   logic [7:0]  mirror_type [NumSlots];
   logic [31:0] mirror_crc [NumSlots];
   logic [4:0]  cfg_slots;
   logic [8:0]  cfg_bytes;
   int unsigned wr_slot, rd_slot, fill_len, rd_offset;
   logic [31:0] fill_crc;
   bit          rd_verified;
   logic [31:0] n_overflow, n_crc_err, n_written, n_delivered;

   ring_rsp_type expected_rsps [$];
   int          errors;
   int          cycles;
   bit          idling_on;
   int          ready_hold;

   crc_checked_packet_ring_core uut (.*);

   // 10 ns clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // reflected crc-32, one bit at a time
   function automatic logic [31:0] crc32_update(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         if (c[0] ^ b[i]) begin
            c = (c >> 1) ^ ccpr_pkg::CrcPoly;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   function automatic int unsigned ring_slots();
      if (cfg_slots < 2) return 2;
      if (cfg_slots > NumSlots) return NumSlots;
      return 32'(cfg_slots);
   endfunction

   function automatic int unsigned payload_cap();
      int unsigned b;
      b = 32'(cfg_bytes);
      if (b < ccpr_pkg::HdrBytes + 1) b = ccpr_pkg::HdrBytes + 1;
      if (b > SlotStride) b = SlotStride;
      return b - ccpr_pkg::HdrBytes;
   endfunction

   function automatic int unsigned advance(input int unsigned i);
      return (i + 1 >= ring_slots()) ? 0 : i + 1;
   endfunction

   function automatic logic [3:0] unread_packets();
      int unsigned p;
      p = (wr_slot >= rd_slot) ? wr_slot - rd_slot : ring_slots() - rd_slot + wr_slot;
      return p[3:0];
   endfunction

   function automatic ring_rsp_type make_rsp(input logic [2:0] st, input logic [7:0] b,
                                             input logic bv, input logic lst,
                                             input logic [7:0] ty, input logic [7:0] sz);
      ring_rsp_type r;
      r.status = st;
      r.out_byte = b;
      r.byte_valid = bv;
      r.last = lst;
      r.msg_type = ty;
      r.size = sz;
      r.pending = unread_packets();
      r.overflows = n_overflow;
      r.crc_errors = n_crc_err;
      r.written = n_written;
      r.delivered = n_delivered;
      return r;
   endfunction

   // advances the mirror by one accepted request; has_rsp tells whether a result follows
   function automatic void ring_predict(input logic op, input logic [7:0] data,
                                        input logic present, input logic lst,
                                        input logic [7:0] mtype,
                                        output bit has_rsp, output ring_rsp_type r);
      int unsigned cap, s, sz;
      logic [31:0] c;
      logic [7:0]  ty, b;
      logic        ends;
      has_rsp = 1'b1;
      if (op == ccpr_pkg::OpPush) begin
         cap = payload_cap();
         if (present) begin
            if (fill_len < cap) begin
               mirror_store[wr_slot*SlotStride + fill_len] = data;
               fill_crc = crc32_update(fill_crc, data);
            end
            if (fill_len <= cap) fill_len++;
         end
         if (!lst) begin
            has_rsp = 1'b0;
            return;
         end
         if (fill_len > cap) begin
            r = make_rsp(ccpr_pkg::StTooLarge, 8'd0, 1'b0, 1'b0, 8'd0, 8'd0);
         end else if (advance(wr_slot) == rd_slot) begin
            n_overflow++;
            r = make_rsp(ccpr_pkg::StFull, 8'd0, 1'b0, 1'b0, 8'd0, 8'd0);
         end else begin
            mirror_size[wr_slot] = fill_len[7:0];
            mirror_type[wr_slot] = mtype;
            mirror_crc[wr_slot] = fill_crc ^ ccpr_pkg::CrcInit;
            wr_slot = advance(wr_slot);
            n_written++;
            r = make_rsp(ccpr_pkg::StOk, 8'd0, 1'b0, 1'b0, 8'd0, 8'd0);
         end
         fill_len = 0;
         fill_crc = ccpr_pkg::CrcInit;
         return;
      end
      if (rd_slot == wr_slot) begin
         r = make_rsp(ccpr_pkg::StEmpty, 8'd0, 1'b0, 1'b0, 8'd0, 8'd0);
         return;
      end
      s = rd_slot;
      sz = 32'(mirror_size[s]);
      ty = mirror_type[s];
      // first pop of a packet rechecks the stored payload
      if (!rd_verified) begin
         c = ccpr_pkg::CrcInit;
         for (int i = 0; i < sz; i++) c = crc32_update(c, mirror_store[s*SlotStride + i]);
         if ((c ^ ccpr_pkg::CrcInit) != mirror_crc[s]) begin
            n_crc_err++;
            rd_slot = advance(rd_slot);
            rd_offset = 0;
            r = make_rsp(ccpr_pkg::StCrcSkip, 8'd0, 1'b0, 1'b0, ty, sz[7:0]);
            return;
         end
         rd_verified = 1'b1;
      end
      if (sz == 0) begin
         rd_slot = advance(rd_slot);
         n_delivered++;
         rd_verified = 1'b0;
         rd_offset = 0;
         r = make_rsp(ccpr_pkg::StOk, 8'd0, 1'b0, 1'b1, ty, 8'd0);
         return;
      end
      b = mirror_store[s*SlotStride + rd_offset];
      rd_offset = (rd_offset + 1) & 8'hFF;
      ends = (rd_offset >= sz);
      if (ends) begin
         rd_slot = advance(rd_slot);
         n_delivered++;
         rd_verified = 1'b0;
         rd_offset = 0;
      end
      r = make_rsp(ccpr_pkg::StOk, b, 1'b1, ends, ty, sz[7:0]);
   endfunction

   function automatic void check_field(input string name, input logic [31:0] exp_v,
                                       input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         errors++;
         $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, exp_v, act_v);
      end
   endfunction

   // scoreboard: results are checked before the same edge's request is predicted
   always @(posedge clock) begin
      ring_rsp_type e;
      ring_rsp_type p;
      bit        has_rsp;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               errors++;
               $display("%0t unexpected result transaction, status %0d", $time, rsp_status);
            end else begin
               e = expected_rsps.pop_front();
               check_field("status", 32'(e.status), 32'(rsp_status));
               check_field("out_byte", 32'(e.out_byte), 32'(rsp_out_byte));
               check_field("out_byte_valid", 32'(e.byte_valid), 32'(rsp_out_byte_valid));
               check_field("out_last", 32'(e.last), 32'(rsp_out_last));
               check_field("out_type", 32'(e.msg_type), 32'(rsp_out_type));
               check_field("out_size", 32'(e.size), 32'(rsp_out_size));
               check_field("pending_count", 32'(e.pending), 32'(rsp_pending_count));
               check_field("overflow_count", e.overflows, rsp_overflow_count);
               check_field("crc_error_count", e.crc_errors, rsp_crc_error_count);
               check_field("written_count", e.written, rsp_written_count);
               check_field("read_count", e.delivered, rsp_read_count);
            end
         end
         if (req_valid && req_ready) begin
            ring_predict(req_opcode, req_data_byte, req_byte_present, req_last_byte,
                         req_message_type, has_rsp, p);
            // rows with a hand-typed status override the predicted one
            if (has_rsp && drv_st_known) p.status = drv_st;
            if (has_rsp) expected_rsps.push_back(p);
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == ccpr_pkg::RegSlotCount) cfg_slots = csr_data[4:0];
            else cfg_bytes = csr_data;
         end
      end
   end

   // receiver stalls in bursts of random length
   always @(posedge clock) begin
      if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
         rsp_ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
         ready_hold <= int'($urandom_range(0, 16));
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // one request transaction; called and returns at a rising edge
   task automatic send_req(input logic [0:0] op, input logic [7:0] data, input logic present,
                           input logic lst, input logic [7:0] mtype,
                           input bit st_known, input logic [2:0] st);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_data_byte <= data;
      req_byte_present <= present;
      req_last_byte <= lst;
      req_message_type <= mtype;
      drv_st_known <= st_known;
      drv_st <= st;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic pop_req();
      send_req(ccpr_pkg::OpPop, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0, ccpr_pkg::StOk);
   endtask

   // sender holds off until every expected result is back, plus push latency
   task automatic wait_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // empties the ring so the next register write lands on an idle block
   task automatic drain_ring();
      while (rd_slot != wr_slot) pop_req();
      wait_quiet();
   endtask

   task automatic write_reg(input logic idx, input logic [8:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // one packet of random content; mostly short, now and then at or past the cap
   task automatic push_packet(output int n_items);
      int unsigned len, pick, cap;
      logic [7:0]  mtype;
      cap = payload_cap();
      pick = $urandom_range(0, 99);
      if (pick < 85) len = $urandom_range(0, 6);
      else if (pick < 95) len = $urandom_range(0, cap);
      else len = cap + $urandom_range(1, 3);
      mtype = 8'($urandom_range(0, 255));
      n_items = 0;
      if (len == 0) begin
         send_req(ccpr_pkg::OpPush, 8'($urandom_range(0, 255)), 1'b0, 1'b1, mtype, 1'b0,
                  ccpr_pkg::StOk);
         n_items = 1;
         return;
      end
      for (int unsigned i = 0; i < len; i++) begin
         // stray byte-less pushes that the block just ignores
         if ($urandom_range(0, 19) == 0)
            send_req(ccpr_pkg::OpPush, 8'($urandom_range(0, 255)), 1'b0, 1'b0,
                     8'($urandom_range(0, 255)), 1'b0, ccpr_pkg::StOk);
         send_req(ccpr_pkg::OpPush, 8'($urandom_range(0, 255)), 1'b1, i == len - 1, mtype,
                  1'b0, ccpr_pkg::StOk);
         n_items++;
      end
   endtask

   // random phase: packets interleaved with pop bursts
   task automatic run_phase(input int n_target, input int pop_weight);
      int done, n;
      done = 0;
      while (done < n_target) begin
         if ($urandom_range(0, 99) < pop_weight) begin
            n = int'($urandom_range(1, 10));
            repeat (n) pop_req();
         end else begin
            push_packet(n);
         end
         done += n;
      end
      drain_ring();
   endtask

   stim_row_type rows [] = '{
      '{ccpr_pkg::OpPop,  8'h00, 1'b0, 1'b0, 8'h00, 1'b1, ccpr_pkg::StEmpty},
      '{ccpr_pkg::OpPush, 8'hA5, 1'b1, 1'b1, 8'h5A, 1'b1, ccpr_pkg::StOk},
      '{ccpr_pkg::OpPush, 8'h00, 1'b0, 1'b1, 8'h11, 1'b1, ccpr_pkg::StFull},
      '{ccpr_pkg::OpPop,  8'h00, 1'b0, 1'b0, 8'h00, 1'b1, ccpr_pkg::StOk},
      '{ccpr_pkg::OpPop,  8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1, ccpr_pkg::StEmpty},
      '{ccpr_pkg::OpPush, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0, ccpr_pkg::StOk},
      '{ccpr_pkg::OpPush, 8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1, ccpr_pkg::StTooLarge},
      '{ccpr_pkg::OpPush, 8'h00, 1'b0, 1'b1, 8'hFF, 1'b1, ccpr_pkg::StOk},
      '{ccpr_pkg::OpPop,  8'h00, 1'b0, 1'b0, 8'h00, 1'b0, ccpr_pkg::StOk},
      '{ccpr_pkg::OpPush, 8'hFF, 1'b1, 1'b1, 8'h00, 1'b1, ccpr_pkg::StOk},
      '{ccpr_pkg::OpPush, 8'h5A, 1'b1, 1'b1, 8'hA5, 1'b1, ccpr_pkg::StFull},
      '{ccpr_pkg::OpPop,  8'h00, 1'b0, 1'b0, 8'h00, 1'b0, ccpr_pkg::StOk},
      '{ccpr_pkg::OpPush, 8'h01, 1'b1, 1'b0, 8'h00, 1'b0, ccpr_pkg::StOk},
      '{ccpr_pkg::OpPush, 8'h02, 1'b1, 1'b1, 8'h33, 1'b1, ccpr_pkg::StTooLarge},
      '{ccpr_pkg::OpPush, 8'h77, 1'b0, 1'b0, 8'h77, 1'b0, ccpr_pkg::StOk},
      '{ccpr_pkg::OpPop,  8'h00, 1'b0, 1'b0, 8'h00, 1'b1, ccpr_pkg::StEmpty}
   };

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_opcode <= ccpr_pkg::OpPush;
      req_data_byte <= 8'h00;
      req_byte_present <= 1'b0;
      req_last_byte <= 1'b0;
      req_message_type <= 8'h00;
      csr_valid <= 1'b0;
      csr_index <= ccpr_pkg::RegSlotCount;
      csr_data <= 9'd0;
      drv_st_known <= 1'b0;
      drv_st <= ccpr_pkg::StOk;
      rsp_ready <= 1'b0;
      ready_hold = 0;
      idling_on = 1'b1;
      errors = 0;
      cycles = 0;
      cfg_slots = 5'd16;
      cfg_bytes = 9'd256;
      wr_slot = 0;
      rd_slot = 0;
      fill_len = 0;
      fill_crc = ccpr_pkg::CrcInit;
      rd_offset = 0;
      rd_verified = 1'b0;
      n_overflow = 0;
      n_crc_err = 0;
      n_written = 0;
      n_delivered = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // smallest ring and slot: one packet of one byte fits
      write_reg(ccpr_pkg::RegSlotCount, 9'd2);
      write_reg(ccpr_pkg::RegSlotBytes, 9'd25);
      foreach (rows[i])
         send_req(rows[i].op, rows[i].data, rows[i].present, rows[i].last, rows[i].mtype,
                  rows[i].st_known, rows[i].st);
      wait_quiet();
      drain_ring();

      // reset-sized ring, ring fills often
      write_reg(ccpr_pkg::RegSlotCount, 9'd16);
      write_reg(ccpr_pkg::RegSlotBytes, 9'd256);
      run_phase(150, 25);

      // out-of-range values clamp to the largest ring, smallest slot
      write_reg(ccpr_pkg::RegSlotCount, 9'd31);
      write_reg(ccpr_pkg::RegSlotBytes, 9'd0);
      run_phase(120, 40);
      // mid-run hold-off until everything is back
      wait_quiet();
      run_phase(120, 35);

      // clamp the other way: smallest ring, largest slot
      write_reg(ccpr_pkg::RegSlotCount, 9'd0);
      write_reg(ccpr_pkg::RegSlotBytes, 9'd511);
      run_phase(200, 45);

      // a few random settings
      repeat (3) begin
         write_reg(ccpr_pkg::RegSlotCount, 9'($urandom_range(2, 16)));
         write_reg(ccpr_pkg::RegSlotBytes, 9'($urandom_range(25, 64)));
         run_phase(150, 40);
      end

      // closing stretch with no idling on either side
      idling_on = 1'b0;
      write_reg(ccpr_pkg::RegSlotCount, 9'd5);
      write_reg(ccpr_pkg::RegSlotBytes, 9'd40);
      run_phase(150, 40);

      wait_quiet();
      repeat (20) @(posedge clock);
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
